// ===== hdl/tpbe_pkg.sv =====
// ----------------------------------------------------------------------------
// Tensor polynomial basis evaluator: shared package
// Field widths, command and register codes, fixed-point helpers and the
// one-dimensional Legendre / Lagrange basis evaluation.
// ----------------------------------------------------------------------------
package tpbe_pkg;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned COORD_W    = 16;
  localparam int unsigned VALUE_W    = 18;
  localparam int unsigned TERM_W     = 4;
  localparam int unsigned ORDER_W    = 2;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned DER_W      = 18;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 2;
  localparam int unsigned WIDE_W     = 48;
  localparam int unsigned PROD_W     = COEF_W + DER_W;

  // Number of 1D functions the evaluation formulas cover (Legendre up to cubic).
  localparam int unsigned BASIS_N    = 4;

  localparam int unsigned MAX_ORDER_DEF = 3;
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam logic signed [COORD_W-1:0] ONE_Q14     = 16'sd16384;
  localparam logic signed [COORD_W-1:0] NEG_ONE_Q14 = -16'sd16384;
  localparam logic signed [VALUE_W-1:0] VALUE_MAX   = 18'sd131071;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN   = -18'sd131072;

  typedef enum logic [CMD_W-1:0] {
    CMD_VAL   = 2'd0,
    CMD_DER_A = 2'd1,
    CMD_DER_B = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASIS_KIND = 1'b0,
    REG_POLY_ORDER = 1'b1
  } cfg_reg_e;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [DER_W-1:0]  der_t;

  typedef struct packed {
    coef_t [BASIS_N-1:0] b;
    der_t  [BASIS_N-1:0] d;
  } basis_t;

  // Bits of one queue entry for a given number of functions per direction.
  function automatic int unsigned entry_w(input int unsigned nb);
    entry_w = CMD_W + ORDER_W + 1 + nb * (2 * COEF_W + DER_W);
  endfunction

  // Arithmetic right shift rounding to nearest, ties away from zero.
  function automatic logic signed [WIDE_W-1:0] rnd_shr(input logic signed [WIDE_W-1:0] v,
                                                       input int unsigned s);
    logic [WIDE_W-1:0] mag;
    logic [WIDE_W-1:0] half;
    half = WIDE_W'(1) << (s - 1);
    mag  = v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
    mag  = (mag + half) >> s;
    rnd_shr = v[WIDE_W-1] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [COORD_W-1:0] x);
    if (x > ONE_Q14) begin
      sat_coord = ONE_Q14;
    end else if (x < NEG_ONE_Q14) begin
      sat_coord = NEG_ONE_Q14;
    end else begin
      sat_coord = x;
    end
  endfunction

  // Values and derivatives of the 1D basis in Q14. z2 = z*z, z3 = z*z*z.
  // Unsupported Lagrange orders leave everything at zero.
  function automatic basis_t eval_basis(input logic signed [COORD_W-1:0] z,
                                        input logic signed [2*COORD_W-1:0] z2,
                                        input logic signed [WIDE_W-1:0] z3,
                                        input logic lag,
                                        input logic [ORDER_W-1:0] p);
    logic signed [WIDE_W-1:0] zw;
    logic signed [WIDE_W-1:0] z2w;
    logic signed [WIDE_W-1:0] one14;
    logic signed [WIDE_W-1:0] one28;
    logic signed [WIDE_W-1:0] t;
    basis_t r;
    zw    = WIDE_W'(z);
    z2w   = WIDE_W'(z2);
    one14 = WIDE_W'(ONE_Q14);
    one28 = one14 <<< 14;
    r     = '0;
    if (!lag) begin
      r.b[0] = ONE_Q14;
      r.b[1] = z;
      t      = rnd_shr(z2w * 48'sd3 - one28, 15);
      r.b[2] = t[COEF_W-1:0];
      t      = rnd_shr(z3 * 48'sd5 - (zw * 48'sd3) * one28, 29);
      r.b[3] = t[COEF_W-1:0];
      r.d[1] = DER_W'(ONE_Q14);
      t      = zw * 48'sd3;
      r.d[2] = t[DER_W-1:0];
      t      = rnd_shr(z2w * 48'sd15 - one28 * 48'sd3, 15);
      r.d[3] = t[DER_W-1:0];
    end else if (p == ORDER_W'(1)) begin
      t      = rnd_shr(one14 - zw, 1);
      r.b[0] = t[COEF_W-1:0];
      t      = rnd_shr(one14 + zw, 1);
      r.b[1] = t[COEF_W-1:0];
      r.d[0] = -(DER_W'(ONE_Q14) >>> 1);
      r.d[1] = DER_W'(ONE_Q14) >>> 1;
    end else if (p == ORDER_W'(2)) begin
      t      = rnd_shr(z2w - (zw <<< 14), 15);
      r.b[0] = t[COEF_W-1:0];
      t      = rnd_shr(one28 - z2w, 14);
      r.b[1] = t[COEF_W-1:0];
      t      = rnd_shr(z2w + (zw <<< 14), 15);
      r.b[2] = t[COEF_W-1:0];
      t      = zw - (one14 >>> 1);
      r.d[0] = t[DER_W-1:0];
      t      = -(zw <<< 1);
      r.d[1] = t[DER_W-1:0];
      t      = zw + (one14 >>> 1);
      r.d[2] = t[DER_W-1:0];
    end
    eval_basis = r;
  endfunction

endpackage

// ===== hdl/tpbe_if.sv =====
// ----------------------------------------------------------------------------
// Tensor polynomial basis evaluator: stream interfaces
// Input item channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tpbe_item_if;
  logic                                     valid;
  logic                                     ready;
  logic [tpbe_pkg::CMD_W-1:0]               command;
  logic signed [tpbe_pkg::COORD_W-1:0]      coord_a;
  logic signed [tpbe_pkg::COORD_W-1:0]      coord_b;

  modport source (output valid, command, coord_a, coord_b, input ready);
  modport sink   (input valid, command, coord_a, coord_b, output ready);
endinterface

interface tpbe_result_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [tpbe_pkg::VALUE_W-1:0]      value;
  logic [tpbe_pkg::TERM_W-1:0]              term_index;
  logic                                     last;
  logic                                     bad_setting;

  modport source (output valid, value, term_index, last, bad_setting, input ready);
  modport sink   (input valid, value, term_index, last, bad_setting, output ready);
endinterface

// ===== hdl/tpbe_fifo.sv =====
// ----------------------------------------------------------------------------
// Tensor polynomial basis evaluator: entry queue
// Small register queue between the evaluation front and the product back.
// ----------------------------------------------------------------------------
module tpbe_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = tpbe_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

// ===== hdl/tpbe_front.sv =====
// ----------------------------------------------------------------------------
// Tensor polynomial basis evaluator: front end
// Accepts items, drops meaningless commands, saturates the coordinates and
// evaluates the 1D bases in a three-stage pipeline, then queues one entry.
// ----------------------------------------------------------------------------
module tpbe_front #(
  parameter int unsigned MAX_ORDER = tpbe_pkg::MAX_ORDER_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  tpbe_item_if.sink                              item_i,
  input  logic                                   basis_kind_i,
  input  logic [tpbe_pkg::ORDER_W-1:0]           poly_order_i,
  output logic                                   push_o,
  output logic [tpbe_pkg::entry_w(MAX_ORDER+1)-1:0] entry_o,
  input  logic                                   full_i
);

  localparam int unsigned NB   = MAX_ORDER + 1;
  localparam int unsigned SQ_W = 2 * tpbe_pkg::COORD_W;

  typedef struct packed {
    logic [tpbe_pkg::CMD_W-1:0]   cmd;
    logic [tpbe_pkg::ORDER_W-1:0] ord;
    logic                         bad;
    tpbe_pkg::coef_t [NB-1:0]     ba;
    tpbe_pkg::der_t  [NB-1:0]     da;
    tpbe_pkg::coef_t [NB-1:0]     bb;
  } entry_t;

  logic adv;
  logic s1_v_q, s2_v_q, s3_v_q;

  logic [tpbe_pkg::CMD_W-1:0]                 s1_cmd_q, s2_cmd_q, s3_cmd_q;
  logic signed [tpbe_pkg::COORD_W-1:0]        s1_za_q, s1_zb_q, s2_za_q, s2_zb_q;
  logic signed [tpbe_pkg::COORD_W-1:0]        s3_za_q, s3_zb_q;
  logic signed [2*tpbe_pkg::COORD_W-1:0]      s2_za2_q, s2_zb2_q, s3_za2_q, s3_zb2_q;
  logic signed [tpbe_pkg::WIDE_W-1:0]         s3_za3_q, s3_zb3_q;

  logic [tpbe_pkg::ORDER_W-1:0] p_eff;
  logic                         ok;
  tpbe_pkg::basis_t             basis_a, basis_b;
  entry_t                       entry;

  // The whole pipeline moves unless a finished entry is waiting on a full queue.
  assign adv          = !s3_v_q || !full_i;
  assign item_i.ready = adv;
  assign push_o       = s3_v_q && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= item_i.valid && ((item_i.command == tpbe_pkg::CMD_VAL) ||
                                 (item_i.command == tpbe_pkg::CMD_DER_A) ||
                                 (item_i.command == tpbe_pkg::CMD_DER_B));
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_cmd_q <= item_i.command;
      s1_za_q  <= tpbe_pkg::sat_coord(item_i.coord_a);
      s1_zb_q  <= tpbe_pkg::sat_coord(item_i.coord_b);
      s2_cmd_q <= s1_cmd_q;
      s2_za_q  <= s1_za_q;
      s2_zb_q  <= s1_zb_q;
      s2_za2_q <= SQ_W'(s1_za_q) * SQ_W'(s1_za_q);
      s2_zb2_q <= SQ_W'(s1_zb_q) * SQ_W'(s1_zb_q);
      s3_cmd_q <= s2_cmd_q;
      s3_za_q  <= s2_za_q;
      s3_zb_q  <= s2_zb_q;
      s3_za2_q <= s2_za2_q;
      s3_zb2_q <= s2_zb2_q;
      s3_za3_q <= tpbe_pkg::WIDE_W'(s2_za2_q) * tpbe_pkg::WIDE_W'(s2_za_q);
      s3_zb3_q <= tpbe_pkg::WIDE_W'(s2_zb2_q) * tpbe_pkg::WIDE_W'(s2_zb_q);
    end
  end

  always_comb begin
    if (poly_order_i > tpbe_pkg::ORDER_W'(MAX_ORDER)) begin
      p_eff = tpbe_pkg::ORDER_W'(MAX_ORDER);
    end else begin
      p_eff = poly_order_i;
    end
    ok = !basis_kind_i || (p_eff == tpbe_pkg::ORDER_W'(1)) ||
         (p_eff == tpbe_pkg::ORDER_W'(2));
  end

  assign basis_a = tpbe_pkg::eval_basis(s3_za_q, s3_za2_q, s3_za3_q, basis_kind_i, p_eff);
  assign basis_b = tpbe_pkg::eval_basis(s3_zb_q, s3_zb2_q, s3_zb3_q, basis_kind_i, p_eff);

  always_comb begin
    entry.cmd = s3_cmd_q;
    entry.ord = p_eff;
    entry.bad = !ok;
    for (int n = 0; n < NB; n++) begin
      entry.ba[n] = basis_a.b[n];
      entry.da[n] = basis_a.d[n];
      entry.bb[n] = basis_b.b[n];
    end
  end

  assign entry_o = entry;

endmodule

// ===== hdl/tpbe_back.sv =====
// ----------------------------------------------------------------------------
// Tensor polynomial basis evaluator: product back end
// Walks the (P+1)^2 tensor terms of one queued entry, one multiply per cycle
// unless the output stalls; then rounds and saturates into the result register.
// ----------------------------------------------------------------------------
module tpbe_back #(
  parameter int unsigned MAX_ORDER = tpbe_pkg::MAX_ORDER_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic [tpbe_pkg::entry_w(MAX_ORDER+1)-1:0] entry_i,
  input  logic                                   avail_i,
  output logic                                   pop_o,
  tpbe_result_if.source                          result_o
);

  localparam int unsigned NB = MAX_ORDER + 1;
  localparam int unsigned IW = $clog2(NB);

  typedef struct packed {
    logic [tpbe_pkg::CMD_W-1:0]   cmd;
    logic [tpbe_pkg::ORDER_W-1:0] ord;
    logic                         bad;
    tpbe_pkg::coef_t [NB-1:0]     ba;
    tpbe_pkg::der_t  [NB-1:0]     da;
    tpbe_pkg::coef_t [NB-1:0]     bb;
  } entry_t;

  entry_t                        cur_q;
  logic                          busy_q, busy_d;
  logic [IW-1:0]                 i_q, i_d, j_q, j_d;
  logic [tpbe_pkg::TERM_W-1:0]   k_q, k_d;
  logic                          adv, fire, term_last, pop;
  logic [IW-1:0]                 ord;

  tpbe_pkg::coef_t               op_x;
  tpbe_pkg::der_t                op_y;

  logic                                  pv_q;
  logic signed [tpbe_pkg::PROD_W-1:0]    prod_q;
  logic [tpbe_pkg::TERM_W-1:0]           pk_q;
  logic                                  plast_q, pbad_q;

  logic                                  ov_q;
  logic signed [tpbe_pkg::VALUE_W-1:0]   oval_q;
  logic [tpbe_pkg::TERM_W-1:0]           ok_q;
  logic                                  olast_q, obad_q;

  logic signed [tpbe_pkg::WIDE_W-1:0]    rounded;
  logic signed [tpbe_pkg::VALUE_W-1:0]   sat_val;

  assign adv       = !ov_q || result_o.ready;
  assign fire      = busy_q && adv;
  assign ord       = IW'(cur_q.ord);
  assign term_last = (i_q == ord) && (j_q == ord);
  // The next entry is loaded in the same cycle as the last term of the current one.
  assign pop       = avail_i && (!busy_q || (fire && term_last));
  assign pop_o     = pop;

  always_comb begin
    busy_d = busy_q;
    i_d    = i_q;
    j_d    = j_q;
    k_d    = k_q;
    if (pop) begin
      busy_d = 1'b1;
      i_d    = '0;
      j_d    = '0;
      k_d    = '0;
    end else if (fire) begin
      if (term_last) begin
        busy_d = 1'b0;
      end
      k_d = k_q + 1'b1;
      if (j_q == ord) begin
        j_d = '0;
        i_d = i_q + 1'b1;
      end else begin
        j_d = j_q + 1'b1;
      end
    end
  end

  always_comb begin
    case (cur_q.cmd)
      tpbe_pkg::CMD_VAL: begin
        op_x = cur_q.bb[i_q];
        op_y = tpbe_pkg::DER_W'(cur_q.ba[j_q]);
      end
      tpbe_pkg::CMD_DER_A: begin
        op_x = cur_q.bb[i_q];
        op_y = cur_q.da[j_q];
      end
      tpbe_pkg::CMD_DER_B: begin
        op_x = cur_q.bb[j_q];
        op_y = cur_q.da[i_q];
      end
      default: begin
        op_x = '0;
        op_y = '0;
      end
    endcase
  end

  always_comb begin
    rounded = tpbe_pkg::rnd_shr(tpbe_pkg::WIDE_W'(prod_q), 14);
    if (rounded > tpbe_pkg::WIDE_W'(tpbe_pkg::VALUE_MAX)) begin
      sat_val = tpbe_pkg::VALUE_MAX;
    end else if (rounded < tpbe_pkg::WIDE_W'(tpbe_pkg::VALUE_MIN)) begin
      sat_val = tpbe_pkg::VALUE_MIN;
    end else begin
      sat_val = rounded[tpbe_pkg::VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      i_q    <= '0;
      j_q    <= '0;
      k_q    <= '0;
      pv_q   <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      i_q    <= i_d;
      j_q    <= j_d;
      k_q    <= k_d;
      if (adv) begin
        pv_q <= fire;
        ov_q <= pv_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_q <= entry_i;
    end
    if (adv) begin
      prod_q  <= tpbe_pkg::PROD_W'(op_x) * tpbe_pkg::PROD_W'(op_y);
      pk_q    <= k_q;
      plast_q <= term_last;
      pbad_q  <= cur_q.bad;
      oval_q  <= sat_val;
      ok_q    <= pk_q;
      olast_q <= plast_q;
      obad_q  <= pbad_q;
    end
  end

  assign result_o.valid       = ov_q;
  assign result_o.value       = oval_q;
  assign result_o.term_index  = ok_q;
  assign result_o.last        = olast_q;
  assign result_o.bad_setting = obad_q;

endmodule

// ===== hdl/tensor_polynomial_basis_eval_top.sv =====
// ----------------------------------------------------------------------------
// Tensor polynomial basis evaluator: top level
// Configuration registers, 1D basis front end, entry queue and tensor
// product back end.
//
//   channel    direction  handshake             beat carries
//   item_i     in         valid/ready           command, coord_a, coord_b
//   result_o   out        valid/ready           value, term_index, last, bad_setting
//   cfg        in         cfg_we_i (no wait)    cfg_idx_i, cfg_wdata_i
//
// An item of order P gives (P+1)^2 result beats (16 at order 3), one per cycle
// while the result channel does not stall, and it holds the product sequencer
// of the back end until its last term has been issued.
// Reset is asynchronous, active low; it clears all valid and control state.
// A stalled result channel backs up the queue, then the front pipeline.
// ----------------------------------------------------------------------------
module tensor_polynomial_basis_eval_top #(
  parameter int unsigned MAX_ORDER = tpbe_pkg::MAX_ORDER_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  tpbe_item_if.sink                          item_i,
  tpbe_result_if.source                      result_o,
  input  logic                               cfg_we_i,
  input  logic [tpbe_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tpbe_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  localparam int unsigned EW = tpbe_pkg::entry_w(MAX_ORDER + 1);

  logic                          kind_q;
  logic [tpbe_pkg::ORDER_W-1:0]  order_q;

  logic          push, full, pop, empty;
  logic [EW-1:0] wdata, rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= 1'b0;
      order_q <= tpbe_pkg::ORDER_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tpbe_pkg::REG_BASIS_KIND: kind_q  <= cfg_wdata_i[0];
        tpbe_pkg::REG_POLY_ORDER: order_q <= cfg_wdata_i[tpbe_pkg::ORDER_W-1:0];
      endcase
    end
  end

  tpbe_front #(
    .MAX_ORDER (MAX_ORDER)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item_i),
    .basis_kind_i (kind_q),
    .poly_order_i (order_q),
    .push_o       (push),
    .entry_o      (wdata),
    .full_i       (full)
  );

  tpbe_fifo #(
    .WIDTH (EW),
    .DEPTH (tpbe_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wdata),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (rdata),
    .empty_o (empty)
  );

  tpbe_back #(
    .MAX_ORDER (MAX_ORDER)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .entry_i  (rdata),
    .avail_i  (!empty),
    .pop_o    (pop),
    .result_o (result_o)
  );

endmodule

// ===== sim/tb_tensor_polynomial_basis_eval_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench: tensor polynomial basis evaluator
// Sends items over the valid/ready channel in random bursts against a stalling
// receiver. Each result beat is predicted by an independent fixed-point model of
// the Legendre / Lagrange tensor basis and checked in order. The configuration
// port steps through both basis kinds at all orders between phases.
// ----------------------------------------------------------------------------
module tb_tensor_polynomial_basis_eval_top;
  import tpbe_pkg::*;

  localparam int unsigned CLK_HALF      = 2;
  localparam int unsigned RESET_CYCLES  = 10;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned IDLE_LIMIT    = 4000;
  localparam int unsigned MAX_REPORTS   = 100;
  localparam int unsigned ORDER_CAP     = 3;
  localparam int unsigned PHASES        = 10;
  localparam int unsigned PHASE_ITEMS   = 40;

  localparam logic [CMD_W-1:0] CMD_NONE       = 2'd3;
  localparam logic             BASIS_LEGENDRE = 1'b0;
  localparam logic             BASIS_LAGRANGE = 1'b1;
  localparam longint           Q14_ONE        = 64'sd16384;
  localparam longint           Q28_ONE        = 64'sd1 << 28;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic [TERM_W-1:0]         term_index;
    logic                      last;
    logic                      bad_setting;
  } term_beat_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  tpbe_item_if   item_bus ();
  tpbe_result_if result_bus ();

  tensor_polynomial_basis_eval_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_bus),
    .result_o    (result_bus),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  term_beat_t         pending_terms[$];
  logic               basis_kind_q;
  logic [ORDER_W-1:0] poly_order_q;

  int unsigned burst_left    = 0;
  int unsigned items_sent    = 0;
  int unsigned cmd_none_sent = 0;
  int unsigned beats_checked = 0;
  int unsigned flagged_beats = 0;
  int unsigned error_count   = 0;
  int unsigned idle_cycles   = 0;
  int unsigned stall_left    = 0;
  int unsigned stall_mode    = 0;

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point basis model
  // ---------------------------------------------------------------------------
  function automatic longint round_half_away(input longint v, input int s);
    longint half;
    half = longint'(1) << (s - 1);
    if (v >= 0) begin
      return (v + half) >>> s;
    end
    return -((-v + half) >>> s);
  endfunction

  function automatic longint clamp_coord(input logic signed [COORD_W-1:0] raw);
    longint x;
    x = longint'(raw);
    if (x > Q14_ONE) begin
      x = Q14_ONE;
    end else if (x < -Q14_ONE) begin
      x = -Q14_ONE;
    end
    return x;
  endfunction

  function automatic longint poly_value(input longint z, input bit lag, input int p,
                                        input int n);
    longint z2;
    z2 = z * z;
    if (!lag) begin
      case (n)
        0:       return Q14_ONE;
        1:       return z;
        2:       return round_half_away(3 * z2 - Q28_ONE, 15);
        3:       return round_half_away(5 * z2 * z - 3 * z * Q28_ONE, 29);
        default: return 0;
      endcase
    end else if (p == 1) begin
      case (n)
        0:       return round_half_away(Q14_ONE - z, 1);
        1:       return round_half_away(Q14_ONE + z, 1);
        default: return 0;
      endcase
    end else if (p == 2) begin
      case (n)
        0:       return round_half_away(z * (z - Q14_ONE), 15);
        1:       return round_half_away(Q28_ONE - z2, 14);
        2:       return round_half_away(z * (z + Q14_ONE), 15);
        default: return 0;
      endcase
    end
    return 0;
  endfunction

  function automatic longint poly_slope(input longint z, input bit lag, input int p,
                                        input int n);
    if (!lag) begin
      case (n)
        1:       return Q14_ONE;
        2:       return 3 * z;
        3:       return round_half_away(15 * z * z - 3 * Q28_ONE, 15);
        default: return 0;
      endcase
    end else if (p == 1) begin
      case (n)
        0:       return -(Q14_ONE / 2);
        1:       return Q14_ONE / 2;
        default: return 0;
      endcase
    end else if (p == 2) begin
      case (n)
        0:       return z - Q14_ONE / 2;
        1:       return -2 * z;
        2:       return z + Q14_ONE / 2;
        default: return 0;
      endcase
    end
    return 0;
  endfunction

  // Queues every product beat that one accepted item should produce.
  function automatic void predict_products(input logic [CMD_W-1:0] cmd,
                                           input logic signed [COORD_W-1:0] a,
                                           input logic signed [COORD_W-1:0] b);
    longint     za;
    longint     zb;
    longint     prod;
    longint     v;
    int         p;
    int         n;
    bit         lag;
    bit         ok;
    term_beat_t beat;
    if (cmd == CMD_NONE) begin
      return;
    end
    p   = (int'(poly_order_q) > ORDER_CAP) ? ORDER_CAP : int'(poly_order_q);
    n   = p + 1;
    lag = basis_kind_q;
    ok  = !lag || p == 1 || p == 2;
    za  = clamp_coord(a);
    zb  = clamp_coord(b);
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        v = 0;
        if (ok) begin
          case (cmd)
            CMD_VAL:   prod = poly_value(zb, lag, p, i) * poly_value(za, lag, p, j);
            CMD_DER_A: prod = poly_value(zb, lag, p, i) * poly_slope(za, lag, p, j);
            default:   prod = poly_value(zb, lag, p, j) * poly_slope(za, lag, p, i);
          endcase
          v = round_half_away(prod, 14);
          if (v > longint'(VALUE_MAX)) begin
            v = longint'(VALUE_MAX);
          end else if (v < longint'(VALUE_MIN)) begin
            v = longint'(VALUE_MIN);
          end
        end
        beat.value       = v[VALUE_W-1:0];
        beat.term_index  = TERM_W'(i * n + j);
        beat.last        = (i * n + j == n * n - 1);
        beat.bad_setting = !ok;
        pending_terms.push_back(beat);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stall pattern and in-order check
  // ---------------------------------------------------------------------------
  function automatic void check_beat();
    term_beat_t want;
    if (pending_terms.size() == 0) begin
      error_count++;
      if (error_count <= MAX_REPORTS) begin
        $display("%0t: unexpected beat: value %0d term %0d last %0b bad %0b", $time,
                 result_bus.value, result_bus.term_index, result_bus.last,
                 result_bus.bad_setting);
      end
      return;
    end
    want = pending_terms.pop_front();
    beats_checked++;
    if (result_bus.bad_setting === 1'b1) begin
      flagged_beats++;
    end
    if (result_bus.value !== want.value || result_bus.term_index !== want.term_index ||
        result_bus.last !== want.last || result_bus.bad_setting !== want.bad_setting) begin
      error_count++;
      if (error_count <= MAX_REPORTS) begin
        $display("%0t: mismatch: expected value %0d term %0d last %0b bad %0b,", $time,
                 want.value, want.term_index, want.last, want.bad_setting);
        $display("%0t:           actual   value %0d term %0d last %0b bad %0b", $time,
                 result_bus.value, result_bus.term_index, result_bus.last,
                 result_bus.bad_setting);
      end
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_bus.valid && result_bus.ready) begin
        check_beat();
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 120);
      end else begin
        stall_left--;
      end
      // Mode 0 never stalls; mode 3 accepts a beat only when stall_left is a multiple of 16.
      case (stall_mode)
        0:       result_bus.ready <= 1'b1;
        1:       result_bus.ready <= 1'($urandom_range(0, 1));
        2:       result_bus.ready <= ($urandom_range(0, 7) != 0);
        default: result_bus.ready <= (stall_left % 16 == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (item_bus.valid && item_bus.ready) ||
        (result_bus.valid && result_bus.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic signed [COORD_W-1:0] a,
                           input logic signed [COORD_W-1:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 3);
      burst_left = $urandom_range(1, 16);
      if (gap != 0) begin
        item_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    item_bus.valid   <= 1'b1;
    item_bus.command <= cmd;
    item_bus.coord_a <= a;
    item_bus.coord_b <= b;
    do @(posedge clk_i); while (!item_bus.ready);
    predict_products(cmd, a, b);
    items_sent++;
    if (cmd == CMD_NONE) begin
      cmd_none_sent++;
    end
    burst_left--;
  endtask

  // A command with no meaning yields no beats but may still be in flight when the
  // last expected beat arrives, hence the extra settle cycles.
  task automatic wait_for_idle();
    item_bus.valid <= 1'b0;
    while (pending_terms.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(input logic kind, input logic [ORDER_W-1:0] order);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_BASIS_KIND;
    cfg_wdata_i <= CFG_DATA_W'(kind);
    @(posedge clk_i);
    basis_kind_q = kind;
    cfg_idx_i   <= REG_POLY_ORDER;
    cfg_wdata_i <= CFG_DATA_W'(order);
    @(posedge clk_i);
    poly_order_q = order;
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [COORD_W-1:0] random_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return COORD_W'(int'($urandom_range(0, 32768)) - 16384);
      5, 6:          return COORD_W'($urandom);
      default: begin
        case ($urandom_range(0, 9))
          0:       return 16'sd16384;
          1:       return -16'sd16384;
          2:       return 16'sd0;
          3:       return 16'sh7FFF;
          4:       return 16'sh8000;
          5:       return 16'sd1;
          6:       return -16'sd1;
          7:       return 16'sd8192;
          8:       return -16'sd8192;
          default: return COORD_W'(int'($urandom_range(0, 64)) - 32);
        endcase
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_settings();
    // Legendre at order 1 straight out of reset, with saturating coordinates.
    send_item(CMD_VAL, 16'sd0, 16'sd0);
    send_item(CMD_VAL, 16'sd16384, -16'sd16384);
    send_item(CMD_DER_A, 16'sh7FFF, 16'sh8000);
    send_item(CMD_DER_B, -16'sd16384, 16'sd16384);
    send_item(CMD_NONE, 16'sh1234, -16'sd5);
    send_item(CMD_DER_B, 16'sd1, -16'sd1);
    wait_for_idle();
  endtask

  task automatic test_cubic_extremes();
    write_config(BASIS_LEGENDRE, 2'd3);
    send_item(CMD_VAL, 16'sd16384, 16'sd16384);
    send_item(CMD_VAL, -16'sd16384, -16'sd16384);
    send_item(CMD_DER_A, 16'sd16384, 16'sd16384);
    send_item(CMD_DER_A, -16'sd16384, -16'sd16384);
    send_item(CMD_DER_B, 16'sd16384, -16'sd16384);
    send_item(CMD_DER_B, -16'sd16384, 16'sd16384);
    send_item(CMD_VAL, 16'sh7FFF, 16'sh8000);
    wait_for_idle();
  endtask

  task automatic test_lagrange_and_order_zero();
    write_config(BASIS_LAGRANGE, 2'd2);
    send_item(CMD_DER_A, 16'sh8000, 16'sh7FFF);
    send_item(CMD_DER_B, 16'sd8193, -16'sd8191);
    wait_for_idle();
    // Odd coordinates put the linear nodes exactly on a rounding tie.
    write_config(BASIS_LAGRANGE, 2'd1);
    send_item(CMD_VAL, 16'sd1, -16'sd1);
    send_item(CMD_DER_B, -16'sd3, 16'sd3);
    wait_for_idle();
    // Lagrange at orders 3 and 0 is unsupported and must come back flagged.
    write_config(BASIS_LAGRANGE, 2'd3);
    send_item(CMD_DER_A, 16'sd0, 16'sd0);
    wait_for_idle();
    write_config(BASIS_LAGRANGE, 2'd0);
    send_item(CMD_VAL, 16'sd100, 16'sd100);
    wait_for_idle();
    write_config(BASIS_LEGENDRE, 2'd0);
    send_item(CMD_VAL, 16'sh8000, 16'sh7FFF);
    send_item(CMD_DER_A, 16'sd16384, 16'sd16384);
    send_item(CMD_DER_B, -16'sd16384, 16'sd5);
    wait_for_idle();
  endtask

  task automatic test_random_phases();
    logic               kind;
    logic [ORDER_W-1:0] order;
    logic [CMD_W-1:0]   cmd;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       begin kind = BASIS_LEGENDRE; order = 2'd3; end
        1:       begin kind = BASIS_LAGRANGE; order = 2'd2; end
        2:       begin kind = BASIS_LAGRANGE; order = 2'd1; end
        3:       begin kind = BASIS_LEGENDRE; order = 2'd0; end
        4:       begin kind = BASIS_LAGRANGE; order = 2'd3; end
        5:       begin kind = BASIS_LEGENDRE; order = 2'd1; end
        6:       begin kind = BASIS_LEGENDRE; order = 2'd2; end
        7:       begin kind = BASIS_LAGRANGE; order = 2'd0; end
        default: begin kind = 1'($urandom_range(0, 1)); order = ORDER_W'($urandom); end
      endcase
      write_config(kind, order);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        cmd = ($urandom_range(0, 19) == 0) ? CMD_NONE : CMD_W'($urandom_range(0, 2));
        send_item(cmd, random_coord(), random_coord());
        // Hold the sender back mid-phase until the block has emptied out.
        if (k == PHASE_ITEMS / 2 && (phase == 0 || phase == 6)) begin
          wait_for_idle();
        end
      end
      wait_for_idle();
    end
  endtask

  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = REG_BASIS_KIND;
    cfg_wdata_i      = '0;
    item_bus.valid   = 1'b0;
    item_bus.command = CMD_VAL;
    item_bus.coord_a = '0;
    item_bus.coord_b = '0;
    result_bus.ready = 1'b0;
    basis_kind_q     = BASIS_LEGENDRE;
    poly_order_q     = 2'd1;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_settings();
    test_cubic_extremes();
    test_lagrange_and_order_zero();
    test_random_phases();
    wait_for_idle();

    $display("Run covered %0d items (%0d with the unused command) and %0d result beats,",
             items_sent, cmd_none_sent, beats_checked);
    $display("%0d of them flagged, over both basis kinds at orders 0 to 3; %0d errors.",
             flagged_beats, error_count);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== tensor_polynomial_basis_eval_top.f =====
hdl/tpbe_pkg.sv
hdl/tpbe_if.sv
hdl/tpbe_fifo.sv
hdl/tpbe_front.sv
hdl/tpbe_back.sv
hdl/tensor_polynomial_basis_eval_top.sv
sim/tb_tensor_polynomial_basis_eval_top.sv
